### sv/khe_pkg.sv
package khe_pkg;

  localparam int NumKeys  = 6;
  localparam int MaskW    = 6;
  localparam int KeyIdxW  = 3;
  localparam int KindW    = 3;
  localparam int NumKinds = 5;
  localparam int CfgW     = 8;
  localparam int CntW     = 9;
  localparam int CfgIdxW  = 1;

  typedef enum logic [KindW-1:0] {
    EvPress   = 3'd0,
    EvLong    = 3'd1,
    EvRepeat  = 3'd2,
    EvShort   = 3'd3,
    EvRelease = 3'd4
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLongPress    = 1'b0,
    CfgRepeatPeriod = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] long_press;
    logic [CfgW-1:0] repeat_period;
  } cfg_t;

  // one bit per event kind, bit position equals the kind code
  typedef logic [NumKinds-1:0] ev_mask_t;

endpackage

### sv/key_hold_event_generator_top.sv
// Key hold event generator: press, long-press, auto-repeat, short and
// release events for a set of keys, from per-frame key masks.
// Input channel: one frame per transfer (pressed, held, released masks).
// Output channel: one event per transfer (key, kind, last_of_frame), keys
// in ascending order, and per key press, long or repeat, short, release.
// last_of_frame marks the final event of a frame; a frame that causes no
// event gives no output transfer.
// Flow: the events of a frame are registered in the pending register and then
// moved one at a time into the output register. The input stalls while events
// of the frame remain pending after the current load, so with no output stall
// a frame with no event or with one event does not stall the input; one event
// leaves per cycle through the single output register while the output does
// not stall, and the next frame is taken in the cycle its predecessor's last
// event is loaded. All keys are evaluated at once by one lane per key.
// Config writes (long press and repeat period) take effect on the next frame;
// the user must make them only while idle, the block does not enforce this.
// Reset clears all hold counters, drops pending events and restores the
// register defaults (long press 10, repeat period 5).
// A stalled output holds its event; the input stalls until the pending
// events of the current frame have all been moved into the output register.
module key_hold_event_generator_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [khe_pkg::MaskW-1:0] pressed_mask_i,
  input  logic [khe_pkg::MaskW-1:0] held_mask_i,
  input  logic [khe_pkg::MaskW-1:0] released_mask_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [khe_pkg::KeyIdxW-1:0] key_num_o,
  output logic [khe_pkg::KindW-1:0]   event_kind_o,
  output logic last_of_frame_o,
  input  logic cfg_we_i,
  input  logic [khe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [khe_pkg::CfgW-1:0]    cfg_data_i
);

  khe_pkg::cfg_t     cfg_q;
  khe_pkg::ev_mask_t lane_ev [khe_pkg::NumKeys];
  logic              in_xfer, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press    <= khe_pkg::CfgW'(10);
      cfg_q.repeat_period <= khe_pkg::CfgW'(5);
    end else if (cfg_we_i) begin
      unique case (khe_pkg::cfg_idx_e'(cfg_idx_i))
        khe_pkg::CfgLongPress:    cfg_q.long_press    <= cfg_data_i;
        khe_pkg::CfgRepeatPeriod: cfg_q.repeat_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;

  for (genvar k = 0; k < khe_pkg::NumKeys; k++) begin : g_lane
    logic pr, hd, rl;
    if (k < khe_pkg::MaskW) begin : g_bit
      assign pr = pressed_mask_i[k];
      assign hd = held_mask_i[k];
      assign rl = released_mask_i[k];
    end else begin : g_nobit
      assign pr = 1'b0;
      assign hd = 1'b0;
      assign rl = 1'b0;
    end

    khe_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (in_xfer),
      .pressed_i  (pr),
      .held_i     (hd),
      .released_i (rl),
      .cfg_i      (cfg_q),
      .ev_o       (lane_ev[k])
    );
  end

  khe_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_xfer),
    .frame_ev_i      (lane_ev),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_num_o       (key_num_o),
    .event_kind_o    (event_kind_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

### sv/khe_lane.sv
module khe_lane (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           pressed_i,
  input  logic           held_i,
  input  logic           released_i,
  input  khe_pkg::cfg_t  cfg_i,
  output khe_pkg::ev_mask_t ev_o
);

  localparam logic [khe_pkg::CntW-1:0] CntMax = '1;

  logic [khe_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [khe_pkg::CntW-1:0] c1, c2, lp, rep_at;

  function automatic logic [khe_pkg::CntW-1:0] bump(input logic [khe_pkg::CntW-1:0] c);
    return (c < CntMax) ? c + 1'b1 : CntMax;
  endfunction

  assign lp     = khe_pkg::CntW'(cfg_i.long_press);
  assign rep_at = khe_pkg::CntW'(cfg_i.long_press) + khe_pkg::CntW'(cfg_i.repeat_period);

  always_comb begin
    ev_o = '0;
    c1   = pressed_i ? bump(cnt_q) : cnt_q;
    if (pressed_i) ev_o[khe_pkg::EvPress] = 1'b1;
    c2 = c1;
    if (held_i && c1 != '0) begin
      c2 = bump(c1);
      if (c2 == lp) begin
        ev_o[khe_pkg::EvLong] = 1'b1;
      end else if (c2 == rep_at) begin
        c2 = lp;
        ev_o[khe_pkg::EvRepeat] = 1'b1;
      end
    end
    cnt_d = c2;
    if (released_i && c2 != '0) begin
      if (c2 < lp) ev_o[khe_pkg::EvShort] = 1'b1;
      ev_o[khe_pkg::EvRelease] = 1'b1;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/khe_merge.sv
module khe_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  khe_pkg::ev_mask_t frame_ev_i [khe_pkg::NumKeys],
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [khe_pkg::KeyIdxW-1:0] key_num_o,
  output logic [khe_pkg::KindW-1:0]   event_kind_o,
  output logic              last_of_frame_o
);

  logic [khe_pkg::NumKeys-1:0][khe_pkg::NumKinds-1:0] pend_q, pend_d, pend_rest, pend_after;
  logic                          found, out_load;
  logic [khe_pkg::KeyIdxW-1:0]   sel_key;
  khe_pkg::event_kind_e          sel_kind;
  logic                          out_valid_q;
  logic [khe_pkg::KeyIdxW-1:0]   key_q;
  khe_pkg::event_kind_e          kind_q;
  logic                          last_q;

  // lowest pending event: keys ascending, kinds ascending within a key
  always_comb begin
    found     = 1'b0;
    sel_key   = '0;
    sel_kind  = khe_pkg::EvPress;
    pend_rest = pend_q;
    for (int k = 0; k < khe_pkg::NumKeys; k++) begin
      for (int j = 0; j < khe_pkg::NumKinds; j++) begin
        if (!found && pend_q[k][j]) begin
          found         = 1'b1;
          sel_key       = khe_pkg::KeyIdxW'(k);
          sel_kind      = khe_pkg::event_kind_e'(khe_pkg::KindW'(j));
          pend_rest[k][j] = 1'b0;
        end
      end
    end
  end

  assign out_load   = found && (!out_valid_q || !out_stall_i);
  assign pend_after = out_load ? pend_rest : pend_q;
  assign busy_o     = |pend_after;

  always_comb begin
    pend_d = pend_after;
    if (load_i) begin
      for (int k = 0; k < khe_pkg::NumKeys; k++) begin
        pend_d[k] = frame_ev_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      key_q  <= sel_key;
      kind_q <= sel_kind;
      last_q <= ~|pend_rest;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_num_o       = key_q;
  assign event_kind_o    = kind_q;
  assign last_of_frame_o = last_q;

endmodule

### sv/khe_checker.sv
module khe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic [khe_pkg::MaskW-1:0] pressed_mask_i,
  input logic [khe_pkg::MaskW-1:0] held_mask_i,
  input logic [khe_pkg::MaskW-1:0] released_mask_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [khe_pkg::KeyIdxW-1:0] key_num_o,
  input logic [khe_pkg::KindW-1:0]   event_kind_o,
  input logic last_of_frame_o,
  input logic cfg_we_i,
  input logic [khe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [khe_pkg::CfgW-1:0]    cfg_data_i
);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(key_num_o) && $stable(event_kind_o)
       && $stable(last_of_frame_o)))
    else $error("stalled event changed or dropped");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && pressed_mask_i == '0 && held_mask_i == '0
     && released_mask_i == '0) |=> !in_stall_o)
    else $error("frame without events left the input stalled");

  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_of_frame_o) |=> out_valid_o)
    else $error("gap inside the events of one frame");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o <= khe_pkg::KindW'(khe_pkg::EvRelease)
                     && key_num_o < khe_pkg::KeyIdxW'(khe_pkg::NumKeys)))
    else $error("event fields out of range");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (!in_stall_o && !out_valid_o))
    else $error("config written while busy");

endmodule

bind key_hold_event_generator_top khe_checker u_khe_checker (.*);
